### rtl/core/ebl_pkg.sv
package ebl_pkg;

  localparam int UPC_W   = 5;
  localparam int COUNT_W = 7;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

  localparam logic [1:0] FUNC_PUSH    = 2'd0;
  localparam logic [1:0] FUNC_DEL     = 2'd1;
  localparam logic [1:0] FUNC_RECLASS = 2'd2;

  typedef enum logic [4:0] {
    A_NOP,
    A_LD_PN,
    A_UNL_LINK,
    A_HEAD_N,
    A_CLR_NE,
    A_DEC,
    A_MUL,
    A_DIV,
    A_NEW_CLS,
    A_LD_H,
    A_RD_TAIL,
    A_LD_T,
    A_PUSH_A,
    A_PUSH_B,
    A_PUSH_1,
    A_INC,
    A_OUT
  } act_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_JUMP,
    C_SKIP,
    C_PUSH,
    C_DEL,
    C_EMPTY,
    C_SINGLE,
    C_HEAD_MISS,
    C_DIV_MORE
  } cond_t;

  typedef struct packed {
    act_t             act;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } uword_t;

  localparam logic [UPC_W-1:0] S_IDLE     = 5'd0;
  localparam logic [UPC_W-1:0] S_DISP     = 5'd1;
  localparam logic [UPC_W-1:0] S_SEL      = 5'd2;
  localparam logic [UPC_W-1:0] S_RD_LINK  = 5'd3;
  localparam logic [UPC_W-1:0] S_LD_PN    = 5'd4;
  localparam logic [UPC_W-1:0] S_CHK_ONE  = 5'd5;
  localparam logic [UPC_W-1:0] S_UNLINK   = 5'd6;
  localparam logic [UPC_W-1:0] S_CHK_HEAD = 5'd7;
  localparam logic [UPC_W-1:0] S_HEAD_N   = 5'd8;
  localparam logic [UPC_W-1:0] S_UNL_ONE  = 5'd9;
  localparam logic [UPC_W-1:0] S_UNL_CNT  = 5'd10;
  localparam logic [UPC_W-1:0] S_MUL      = 5'd11;
  localparam logic [UPC_W-1:0] S_DIV      = 5'd12;
  localparam logic [UPC_W-1:0] S_NEW_CLS  = 5'd13;
  localparam logic [UPC_W-1:0] S_PUSH     = 5'd14;
  localparam logic [UPC_W-1:0] S_LD_H     = 5'd15;
  localparam logic [UPC_W-1:0] S_RD_TAIL  = 5'd16;
  localparam logic [UPC_W-1:0] S_LD_T     = 5'd17;
  localparam logic [UPC_W-1:0] S_PUSH_A   = 5'd18;
  localparam logic [UPC_W-1:0] S_PUSH_B   = 5'd19;
  localparam logic [UPC_W-1:0] S_PUSH_ONE = 5'd20;
  localparam logic [UPC_W-1:0] S_PUSH_CNT = 5'd21;
  localparam logic [UPC_W-1:0] S_FIN      = 5'd22;
  localparam logic [UPC_W-1:0] S_OUT      = 5'd23;

  function automatic uword_t ucode(input logic [UPC_W-1:0] pc);
    uword_t w;
    w = '{act: A_NOP, cond: C_JUMP, target: S_IDLE};
    case (pc)
      S_IDLE:     w = '{act: A_NOP,      cond: C_JUMP,      target: S_IDLE};
      S_DISP:     w = '{act: A_NOP,      cond: C_SKIP,      target: S_FIN};
      S_SEL:      w = '{act: A_NOP,      cond: C_PUSH,      target: S_PUSH};
      S_RD_LINK:  w = '{act: A_NOP,      cond: C_NEXT,      target: S_IDLE};
      S_LD_PN:    w = '{act: A_LD_PN,    cond: C_NEXT,      target: S_IDLE};
      S_CHK_ONE:  w = '{act: A_NOP,      cond: C_SINGLE,    target: S_UNL_ONE};
      S_UNLINK:   w = '{act: A_UNL_LINK, cond: C_NEXT,      target: S_IDLE};
      S_CHK_HEAD: w = '{act: A_NOP,      cond: C_HEAD_MISS, target: S_UNL_CNT};
      S_HEAD_N:   w = '{act: A_HEAD_N,   cond: C_JUMP,      target: S_UNL_CNT};
      S_UNL_ONE:  w = '{act: A_CLR_NE,   cond: C_NEXT,      target: S_IDLE};
      S_UNL_CNT:  w = '{act: A_DEC,      cond: C_DEL,       target: S_FIN};
      S_MUL:      w = '{act: A_MUL,      cond: C_NEXT,      target: S_IDLE};
      S_DIV:      w = '{act: A_DIV,      cond: C_DIV_MORE,  target: S_DIV};
      S_NEW_CLS:  w = '{act: A_NEW_CLS,  cond: C_NEXT,      target: S_IDLE};
      S_PUSH:     w = '{act: A_NOP,      cond: C_EMPTY,     target: S_PUSH_ONE};
      S_LD_H:     w = '{act: A_LD_H,     cond: C_NEXT,      target: S_IDLE};
      S_RD_TAIL:  w = '{act: A_RD_TAIL,  cond: C_NEXT,      target: S_IDLE};
      S_LD_T:     w = '{act: A_LD_T,     cond: C_NEXT,      target: S_IDLE};
      S_PUSH_A:   w = '{act: A_PUSH_A,   cond: C_NEXT,      target: S_IDLE};
      S_PUSH_B:   w = '{act: A_PUSH_B,   cond: C_JUMP,      target: S_PUSH_CNT};
      S_PUSH_ONE: w = '{act: A_PUSH_1,   cond: C_NEXT,      target: S_IDLE};
      S_PUSH_CNT: w = '{act: A_INC,      cond: C_NEXT,      target: S_IDLE};
      S_FIN:      w = '{act: A_NOP,      cond: C_NEXT,      target: S_IDLE};
      S_OUT:      w = '{act: A_OUT,      cond: C_JUMP,      target: S_IDLE};
      default:    w = '{act: A_NOP,      cond: C_JUMP,      target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

### rtl/core/ebl_ram.sv
module ebl_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/emptiness_bin_list_manager_core.sv
// The time from the accepting edge to the result strobe is the length of the
// microprogram path, which differs for an error or an unknown function, for push,
// for delete and for a full reclassify: each link memory access takes one registered
// read and the quotient comes one bit per cycle.
// One item at a time; busy falls in the strobe cycle, so a new start is taken there.
// Reset is synchronous and active low: every class list reads empty, the count is zero.
module emptiness_bin_list_manager_core #(
  parameter int NUM_SUPERBLOCKS = 64,
  parameter int NUM_CLASSES     = 8,
  parameter int MAX_BLOCKS      = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_func,
  input  logic [$clog2(NUM_SUPERBLOCKS)-1:0] in_superblock_id,
  input  logic [$clog2(NUM_CLASSES)-1:0]     in_class_idx,
  input  logic [$clog2(MAX_BLOCKS+1)-1:0]    in_total_blocks,
  input  logic [$clog2(MAX_BLOCKS+1)-1:0]    in_free_blocks,
  output logic                               out_valid,
  output logic [$clog2(NUM_CLASSES)-1:0]     out_new_class,
  output logic                               out_head_valid,
  output logic [$clog2(NUM_SUPERBLOCKS)-1:0] out_head_id,
  output logic [ebl_pkg::COUNT_W-1:0]        out_nonfull_count,
  output logic                               out_error
);

  import ebl_pkg::*;

  localparam int IDW = $clog2(NUM_SUPERBLOCKS);
  localparam int CW  = $clog2(NUM_CLASSES);
  localparam int TW  = $clog2(MAX_BLOCKS + 1);
  localparam int PW  = TW + CW;
  localparam int DCW = $clog2(CW + 1);
  localparam logic [IDW-1:0] ID_MAX = IDW'(NUM_SUPERBLOCKS - 1);
  localparam logic [CW-1:0]  C_MAX  = CW'(NUM_CLASSES - 1);

  logic [UPC_W-1:0]       upc_r, upc_nxt;
  logic [NUM_CLASSES-1:0] ne_r, ne_nxt;
  logic [COUNT_W-1:0]     cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CW-1:0]          out_cls_r, out_cls_nxt;
  logic                   out_hv_r, out_hv_nxt;
  logic [IDW-1:0]         out_hid_r, out_hid_nxt;
  logic                   out_err_r, out_err_nxt;

  logic [1:0]     func_r, func_nxt;
  logic [IDW-1:0] id_r, id_nxt;
  logic [CW-1:0]  cls_r, cls_nxt;
  logic [TW-1:0]  total_r, total_nxt;
  logic [TW-1:0]  free_r, free_nxt;
  logic           err_r, err_nxt;
  logic           skip_r, skip_nxt;
  logic [IDW-1:0] p_r, p_nxt;
  logic [IDW-1:0] n_r, n_nxt;
  logic [IDW-1:0] h_r, h_nxt;
  logic [IDW-1:0] t_r, t_nxt;
  logic [PW-1:0]  rem_r, rem_nxt;
  logic [PW-1:0]  dsr_r, dsr_nxt;
  logic [CW-1:0]  q_r, q_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;

  uword_t         uw;
  logic           taken;
  logic           accept;
  logic [IDW-1:0] id_sat;
  logic [CW-1:0]  cls_sat;
  logic           cls_empty_in;
  logic           is_push, is_del, is_rcl;
  logic [TW-1:0]  used;
  logic           qbit;

  logic           prev_we, next_we, head_we;
  logic [IDW-1:0] prev_waddr, prev_wdata, prev_raddr, prev_rdata;
  logic [IDW-1:0] next_waddr, next_wdata, next_rdata;
  logic [IDW-1:0] head_wdata, head_rdata;

  ebl_ram #(.WIDTH(IDW), .DEPTH(NUM_SUPERBLOCKS)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (prev_raddr),
    .rdata (prev_rdata)
  );

  ebl_ram #(.WIDTH(IDW), .DEPTH(NUM_SUPERBLOCKS)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (id_r),
    .rdata (next_rdata)
  );

  ebl_ram #(.WIDTH(IDW), .DEPTH(NUM_CLASSES)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (cls_r),
    .wdata (head_wdata),
    .raddr (cls_r),
    .rdata (head_rdata)
  );

  assign uw     = ucode(upc_r);
  assign busy   = (upc_r != S_IDLE);
  assign accept = start && !busy;

  assign id_sat       = (in_superblock_id > ID_MAX) ? ID_MAX : in_superblock_id;
  assign cls_sat      = (in_class_idx > C_MAX) ? C_MAX : in_class_idx;
  assign cls_empty_in = !ne_r[cls_sat];
  assign is_push      = (in_func == FUNC_PUSH);
  assign is_del       = (in_func == FUNC_DEL);
  assign is_rcl       = (in_func == FUNC_RECLASS);

  assign used = (free_r >= total_r) ? '0 : (total_r - free_r);
  assign qbit = (rem_r >= dsr_r);

  always_comb begin
    case (uw.cond)
      C_NEXT:      taken = 1'b0;
      C_JUMP:      taken = 1'b1;
      C_SKIP:      taken = skip_r;
      C_PUSH:      taken = (func_r == FUNC_PUSH);
      C_DEL:       taken = (func_r == FUNC_DEL);
      C_EMPTY:     taken = !ne_r[cls_r];
      C_SINGLE:    taken = (p_r == id_r);
      C_HEAD_MISS: taken = (h_r != id_r);
      C_DIV_MORE:  taken = (dcnt_r != DCW'(1));
      default:     taken = 1'b0;
    endcase
  end

  always_comb begin
    prev_we    = 1'b0;
    prev_waddr = id_r;
    prev_wdata = id_r;
    next_we    = 1'b0;
    next_waddr = id_r;
    next_wdata = id_r;
    head_we    = 1'b0;
    head_wdata = id_r;
    prev_raddr = (uw.act == A_RD_TAIL) ? h_r : id_r;
    case (uw.act)
      A_UNL_LINK: begin
        prev_we    = 1'b1;
        prev_waddr = n_r;
        prev_wdata = p_r;
        next_we    = 1'b1;
        next_waddr = p_r;
        next_wdata = n_r;
      end
      A_HEAD_N: begin
        head_we    = 1'b1;
        head_wdata = n_r;
      end
      A_PUSH_A: begin
        prev_we    = 1'b1;
        prev_wdata = t_r;
        next_we    = 1'b1;
        next_waddr = t_r;
      end
      A_PUSH_B: begin
        prev_we    = 1'b1;
        prev_waddr = h_r;
        next_we    = 1'b1;
        next_wdata = h_r;
        head_we    = 1'b1;
      end
      A_PUSH_1: begin
        prev_we = 1'b1;
        next_we = 1'b1;
        head_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    upc_nxt       = taken ? uw.target : upc_r + UPC_W'(1);
    ne_nxt        = ne_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_cls_nxt   = out_cls_r;
    out_hv_nxt    = out_hv_r;
    out_hid_nxt   = out_hid_r;
    out_err_nxt   = out_err_r;
    func_nxt      = func_r;
    id_nxt        = id_r;
    cls_nxt       = cls_r;
    total_nxt     = total_r;
    free_nxt      = free_r;
    err_nxt       = err_r;
    skip_nxt      = skip_r;
    p_nxt         = p_r;
    n_nxt         = n_r;
    h_nxt         = h_r;
    t_nxt         = t_r;
    rem_nxt       = rem_r;
    dsr_nxt       = dsr_r;
    q_nxt         = q_r;
    dcnt_nxt      = dcnt_r;
    if (upc_r == S_IDLE) begin
      upc_nxt = accept ? S_DISP : S_IDLE;
      if (accept) begin
        func_nxt  = in_func;
        id_nxt    = id_sat;
        cls_nxt   = cls_sat;
        total_nxt = in_total_blocks;
        free_nxt  = in_free_blocks;
        err_nxt   = (is_del && cls_empty_in) ||
                    (is_rcl && (cls_empty_in || (in_total_blocks == '0)));
        skip_nxt  = err_nxt || !(is_push || is_del || is_rcl);
      end
    end
    case (uw.act)
      A_LD_PN: begin
        p_nxt = prev_rdata;
        n_nxt = next_rdata;
      end
      A_UNL_LINK: h_nxt = head_rdata;
      A_CLR_NE:   ne_nxt[cls_r] = 1'b0;
      A_DEC: begin
        if ((cls_r != '0) && (cnt_r != '0)) begin
          cnt_nxt = cnt_r - COUNT_W'(1);
        end
      end
      A_MUL: begin
        rem_nxt  = PW'(used) * PW'(C_MAX);
        dsr_nxt  = PW'(total_r) << (CW - 1);
        q_nxt    = '0;
        dcnt_nxt = DCW'(CW);
      end
      A_DIV: begin
        rem_nxt  = qbit ? (rem_r - dsr_r) : rem_r;
        dsr_nxt  = dsr_r >> 1;
        q_nxt    = (q_r << 1) | CW'(qbit);
        dcnt_nxt = dcnt_r - DCW'(1);
      end
      A_NEW_CLS: cls_nxt = C_MAX - q_r;
      A_LD_H:    h_nxt = head_rdata;
      A_LD_T:    t_nxt = prev_rdata;
      A_PUSH_1:  ne_nxt[cls_r] = 1'b1;
      A_INC: begin
        if ((cls_r != '0) && (cnt_r != COUNT_MAX)) begin
          cnt_nxt = cnt_r + COUNT_W'(1);
        end
      end
      A_OUT: begin
        out_valid_nxt = 1'b1;
        out_cls_nxt   = cls_r;
        out_hv_nxt    = ne_r[cls_r];
        out_hid_nxt   = ne_r[cls_r] ? head_rdata : '0;
        out_err_nxt   = err_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= S_IDLE;
      ne_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      ne_r        <= ne_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_cls_r <= out_cls_nxt;
    out_hv_r  <= out_hv_nxt;
    out_hid_r <= out_hid_nxt;
    out_err_r <= out_err_nxt;
  end

  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    id_r    <= id_nxt;
    cls_r   <= cls_nxt;
    total_r <= total_nxt;
    free_r  <= free_nxt;
    err_r   <= err_nxt;
    skip_r  <= skip_nxt;
    p_r     <= p_nxt;
    n_r     <= n_nxt;
    h_r     <= h_nxt;
    t_r     <= t_nxt;
    rem_r   <= rem_nxt;
    dsr_r   <= dsr_nxt;
    q_r     <= q_nxt;
    dcnt_r  <= dcnt_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_new_class     = out_cls_r;
  assign out_head_valid    = out_hv_r;
  assign out_head_id       = out_hid_r;
  assign out_nonfull_count = cnt_r;
  assign out_error         = out_err_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("Accepted beat did not start the sequencer.");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("Result strobe while the sequencer is still busy.");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("Result strobe held for more than one cycle.");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    upc_r == S_DIV |-> dcnt_r != '0)
    else $error("Divider step with an exhausted bit count.");

  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    upc_r == S_NEW_CLS |-> q_r <= C_MAX)
    else $error("Fullness quotient exceeds the top class.");

endmodule
